// ===== rtl/pfed_pkg.sv =====
`default_nettype none

package pfed_pkg;

   localparam int LEVEL_W     = 7;
   localparam int LEVEL_COUNT = 87;
   localparam int THR_W       = 29;
   localparam int BIT_W       = $clog2(LEVEL_W);

   // entry L-1 is the smallest quotient that reaches level L
   localparam logic [THR_W-1:0] LEVEL_THR [LEVEL_COUNT] = '{
      29'd2, 29'd2, 29'd2, 29'd3, 29'd4, 29'd4, 29'd6, 29'd7, 29'd8,
      29'd10, 29'd13, 29'd16, 29'd20, 29'd26, 29'd32, 29'd40, 29'd51, 29'd64, 29'd80,
      29'd100, 29'd126, 29'd159, 29'd200, 29'd252, 29'd317, 29'd399, 29'd502,
      29'd631, 29'd795,
      29'd1000, 29'd1259, 29'd1585, 29'd1996, 29'd2512, 29'd3163, 29'd3982,
      29'd5012, 29'd6310, 29'd7944,
      29'd10000, 29'd12590, 29'd15849, 29'd19953, 29'd25119, 29'd31623,
      29'd39811, 29'd50119, 29'd63096, 29'd79433,
      29'd100000, 29'd125893, 29'd158490, 29'd199527, 29'd251189, 29'd316228,
      29'd398108, 29'd501188, 29'd630958, 29'd794329,
      29'd1000000, 29'd1258926, 29'd1584894, 29'd1995263, 29'd2511887,
      29'd3162278, 29'd3981072, 29'd5011873, 29'd6309574, 29'd7943283,
      29'd10000000, 29'd12589255, 29'd15848932, 29'd19952624, 29'd25118865,
      29'd31622777, 29'd39810718, 29'd50118724, 29'd63095735, 29'd79432824,
      29'd100000000, 29'd125892542, 29'd158489320, 29'd199526232,
      29'd251188644, 29'd316227767, 29'd398107171, 29'd501187234
   };

   function automatic logic [THR_W-1:0] level_threshold(input logic [LEVEL_W-1:0] lvl);
      logic [THR_W-1:0] thr;
      thr = '0;
      if (lvl != '0 && lvl <= LEVEL_W'(LEVEL_COUNT)) begin
         thr = LEVEL_THR[lvl - LEVEL_W'(1)];
      end
      return thr;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/pfed_sub.sv =====
`default_nettype none

module pfed_sub #(
   parameter int W = 48
) (
   input  wire logic [W-1:0] op_a,
   input  wire logic [W-1:0] op_b,
   output logic      [W-1:0] diff,
   output logic              ge
);

   logic borrow;

   assign {borrow, diff} = {1'b0, op_a} - {1'b0, op_b};
   assign ge = ~borrow;

endmodule

`default_nettype wire

// ===== rtl/pfed_acc.sv =====
`default_nettype none

module pfed_acc #(
   parameter int MAX_SAMPLES = 65536,
   parameter int CNT_W       = 17,
   parameter int SUM_W       = 48
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               take,
   input  wire logic signed [15:0] sample,
   input  wire logic               clear,
   output logic        [SUM_W-1:0] sum,
   output logic        [CNT_W-1:0] count,
   output logic                    overflow
);

   logic [15:0]      mag;
   logic [31:0]      square;
   logic             counted;
   logic [SUM_W-1:0] sum_ff;
   logic [CNT_W-1:0] count_ff;
   logic             over_ff;
   logic [31:0]      sq_ff;
   logic             sq_vld_ff;

   assign mag     = sample[15] ? (~sample + 16'd1) : sample;
   assign square  = {16'd0, mag} * {16'd0, mag};
   assign counted = count_ff < CNT_W'(MAX_SAMPLES);

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         sum_ff    <= '0;
         count_ff  <= '0;
         over_ff   <= 1'b0;
         sq_vld_ff <= 1'b0;
      end else begin
         sq_vld_ff <= take && counted;
         if (sq_vld_ff) begin
            sum_ff <= sum_ff + SUM_W'(sq_ff);
         end
         if (take) begin
            if (counted) begin
               count_ff <= count_ff + CNT_W'(1);
            end else begin
               over_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         sq_ff <= square;
      end
   end

   assign sum      = sum_ff;
   assign count    = count_ff;
   assign overflow = over_ff;

endmodule

`default_nettype wire

// ===== rtl/pfed_div.sv =====
`default_nettype none

module pfed_div #(
   parameter int CNT_W = 17,
   parameter int SUM_W = 48
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic [SUM_W-1:0]            sum,
   input  wire logic [CNT_W-1:0]            count,
   output logic                             done,
   output logic [pfed_pkg::LEVEL_W-1:0]     level,
   output logic                             silent
);

   localparam int DW     = SUM_W - 1;
   localparam int UW     = SUM_W;
   localparam int STEP_W = $clog2(DW);

   typedef enum logic [1:0] {S_IDLE, S_DIV, S_LVL} state_type;

   state_type                        state_ff, state_in;
   logic [CNT_W-1:0]                 rem_ff, rem_in;
   logic [CNT_W-1:0]                 div_ff, div_in;
   logic [DW-1:0]                    quo_ff, quo_in;
   logic [STEP_W-1:0]                step_ff, step_in;
   logic [pfed_pkg::BIT_W-1:0]       bit_ff, bit_in;
   logic [pfed_pkg::LEVEL_W-1:0]     lvl_ff, lvl_in;
   logic                             silent_ff, silent_in;
   logic                             done_ff, done_in;

   logic [CNT_W:0]                   rem_sh;
   logic [pfed_pkg::LEVEL_W-1:0]     cand;
   logic [UW-1:0]                    op_a, op_b, diff;
   logic                             ge;

   pfed_sub #(.W(UW)) u_sub (
      .op_a (op_a),
      .op_b (op_b),
      .diff (diff),
      .ge   (ge)
   );

   always_comb begin
      rem_sh = {rem_ff, quo_ff[DW-1]};
      cand   = lvl_ff | (pfed_pkg::LEVEL_W'(1) << bit_ff);
      if (state_ff == S_LVL) begin
         op_a = UW'(quo_ff);
         op_b = UW'(pfed_pkg::level_threshold(cand));
      end else begin
         op_a = UW'(rem_sh);
         op_b = UW'(div_ff);
      end
   end

   always_comb begin
      state_in  = state_ff;
      rem_in    = rem_ff;
      div_in    = div_ff;
      quo_in    = quo_ff;
      step_in   = step_ff;
      bit_in    = bit_ff;
      lvl_in    = lvl_ff;
      silent_in = silent_ff;
      done_in   = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               rem_in   = '0;
               div_in   = count;
               quo_in   = sum[SUM_W-1:1];
               step_in  = '0;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            rem_in  = ge ? diff[CNT_W-1:0] : rem_sh[CNT_W-1:0];
            quo_in  = {quo_ff[DW-2:0], ge};
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(DW - 1)) begin
               bit_in   = pfed_pkg::BIT_W'(pfed_pkg::LEVEL_W - 1);
               lvl_in   = '0;
               state_in = S_LVL;
            end
         end
         S_LVL: begin
            if (ge && cand <= pfed_pkg::LEVEL_W'(pfed_pkg::LEVEL_COUNT)) begin
               lvl_in = cand;
            end
            bit_in = bit_ff - pfed_pkg::BIT_W'(1);
            if (bit_ff == '0) begin
               silent_in = (quo_ff == '0);
               done_in   = 1'b1;
               state_in  = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      rem_ff    <= rem_in;
      div_ff    <= div_in;
      quo_ff    <= quo_in;
      step_ff   <= step_in;
      bit_ff    <= bit_in;
      lvl_ff    <= lvl_in;
      silent_ff <= silent_in;
   end

   assign done   = done_ff;
   assign level  = lvl_ff;
   assign silent = silent_ff;

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> state_ff == S_IDLE)
      else $error("divider started while busy");

   a_rem_below_div: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DIV |-> rem_ff < div_ff)
      else $error("partial remainder not below divisor");

endmodule

`default_nettype wire

// ===== rtl/pcm_frame_energy_db.sv =====
// pcm frame energy meter, integer decibel level per frame
//
// req channel: one signed pcm sample per transaction, req_frame_end marks
// the last sample of a frame. rsp channel: one transaction per frame with
// rsp_level_db = floor(10*log10(energy / (2*samples))), rsp_silent when
// that quotient is zero, rsp_frame_overflow when samples past MAX_SAMPLES
// were dropped.
// a sample that does not end a frame leaves req_stall low, and the squaring
// stage and accumulator keep up every cycle.
// after the frame_end transaction req_stall goes high while a restoring
// divider retires one quotient bit per cycle (31 + clog2(MAX_SAMPLES+1) - 1
// bits, 47 at the default bound) through one shared subtractor, followed by
// a seven step binary search of the level table on the same subtractor.
// the search result passes through a pending hand-off state into an
// output register that raises rsp_valid; sampling of the next frame
// resumes while rsp waits, and a stalled rsp only holds up the next
// frame_end. reset clears the accumulator, the sample count and rsp_valid.
`default_nettype none

module pcm_frame_energy_db #(
   parameter int MAX_SAMPLES = 65536
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire logic signed [15:0]              req_sample,
   input  wire logic                            req_frame_end,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic [pfed_pkg::LEVEL_W-1:0]         rsp_level_db,
   output logic                                 rsp_silent,
   output logic                                 rsp_frame_overflow
);

   localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
   localparam int SUM_W = 31 + CNT_W;

   typedef enum logic [2:0] {ST_IDLE, ST_FLUSH, ST_START, ST_RUN, ST_PEND} state_type;

   state_type                    state_ff, state_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [pfed_pkg::LEVEL_W-1:0] level_ff, level_in;
   logic                         silent_ff, silent_in;
   logic                         over_ff, over_in;

   logic                         take;
   logic                         clear;
   logic                         slot_free;
   logic [SUM_W-1:0]             sum;
   logic [CNT_W-1:0]             count;
   logic                         overflow;
   logic                         div_done;
   logic [pfed_pkg::LEVEL_W-1:0] div_level;
   logic                         div_silent;

   assign req_stall = (state_ff != ST_IDLE);
   assign take      = req_valid && !req_stall;
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign clear     = (state_ff == ST_PEND) && slot_free;

   pfed_acc #(
      .MAX_SAMPLES (MAX_SAMPLES),
      .CNT_W       (CNT_W),
      .SUM_W       (SUM_W)
   ) u_acc (
      .clock    (clock),
      .reset    (reset),
      .take     (take),
      .sample   (req_sample),
      .clear    (clear),
      .sum      (sum),
      .count    (count),
      .overflow (overflow)
   );

   pfed_div #(
      .CNT_W (CNT_W),
      .SUM_W (SUM_W)
   ) u_div (
      .clock  (clock),
      .reset  (reset),
      .start  (state_ff == ST_START),
      .sum    (sum),
      .count  (count),
      .done   (div_done),
      .level  (div_level),
      .silent (div_silent)
   );

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      level_in     = level_ff;
      silent_in    = silent_ff;
      over_in      = over_ff;
      case (state_ff)
         ST_IDLE: begin
            if (take && req_frame_end) begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            state_in = ST_START;
         end
         ST_START: begin
            state_in = ST_RUN;
         end
         ST_RUN: begin
            if (div_done) begin
               state_in = ST_PEND;
            end
         end
         ST_PEND: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               level_in     = div_level;
               silent_in    = div_silent;
               over_in      = overflow;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      level_ff  <= level_in;
      silent_ff <= silent_in;
      over_ff   <= over_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_level_db       = level_ff;
   assign rsp_silent         = silent_ff;
   assign rsp_frame_overflow = over_ff;

   a_rsp_from_pend: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff == ST_PEND))
      else $error("result raised outside the hand-off state");

   a_stall_after_end: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_frame_end) |=> req_stall)
      else $error("frame end transaction did not stall the request side");

   a_done_in_run: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == ST_RUN)
      else $error("divider finished outside the run state");

   a_silent_level: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_silent) |-> rsp_level_db == '0)
      else $error("silent frame with nonzero level");

endmodule

`default_nettype wire
